>>> design/woas_pkg.sv
// Shared types, constants and the Hann coefficient function for the overlap-add synthesizer.
`default_nettype none

package woas_pkg;

  localparam int unsigned HopSizeDefault = 256;

  localparam logic [63:0] PI_Q30  = 64'd3373259426;
  localparam logic [63:0] ONE_Q30 = 64'd1 << 30;

  typedef logic signed [15:0] sample_t;
  typedef logic        [15:0] coef_t;

  // Hann coefficient sin^2(x) in Q0.16 from the Q30 angle x, via a short
  // nested series for sin. Used only to build the constant table.
  function automatic coef_t hann_coef(input logic [63:0] x);
    logic [63:0] x2;
    logic [63:0] t;
    logic [63:0] s;
    logic [63:0] w;
    x2 = (x * x) >> 30;
    t  = ONE_Q30;
    t  = ONE_Q30 - (((x2 * t) >> 30) / 64'd156);
    t  = ONE_Q30 - (((x2 * t) >> 30) / 64'd110);
    t  = ONE_Q30 - (((x2 * t) >> 30) / 64'd72);
    t  = ONE_Q30 - (((x2 * t) >> 30) / 64'd42);
    t  = ONE_Q30 - (((x2 * t) >> 30) / 64'd20);
    t  = ONE_Q30 - (((x2 * t) >> 30) / 64'd6);
    s  = (x * t) >> 30;
    w  = (s * s + (64'd1 << 43)) >> 44;
    if (w > 64'd65535) begin
      w = 64'd65535;
    end
    return w[15:0];
  endfunction

endpackage

`default_nettype wire

>>> design/windowed_overlap_add_synth_top.sv
// Top level of the Hann weighted 50 percent overlap-add synthesizer.
// A first-half sample passes stage A and stage B, and its overlap sum is then loaded
// into the output register; it then waits there until taken.
// Throughput: one sample per cycle while the output register is not stalled, set by the
// single windowing multiplier stage and the tail delay line, which shifts once per sample.
// Reset clears the tail cells, the frame position and sets the window enable.
`default_nettype none

module windowed_overlap_add_synth_top #(
  parameter int unsigned HOP_SIZE = woas_pkg::HopSizeDefault
) (
  input  wire                    clk_i,
  input  wire                    rst_ni,
  input  wire                    cfg_we_i,
  input  wire                    cfg_wdata_i,
  input  wire                    in_valid_i,
  output logic                   in_ready_o,
  input  wire woas_pkg::sample_t frame_sample_i,
  output logic                   out_valid_o,
  input  wire                    out_ready_i,
  output woas_pkg::sample_t      out_sample_o,
  output logic                   hop_last_o
);
  import woas_pkg::*;

  localparam int unsigned AW = $clog2(HOP_SIZE);
  localparam int unsigned PW = $clog2(2 * HOP_SIZE);

  logic          win_en_q;
  logic [PW-1:0] pos_q, pos_d;
  logic          first_half;
  logic [AW-1:0] rom_addr;
  logic          in_xfer;

  logic    a_valid_q, a_en_q, a_emit_q, a_last_q;
  sample_t a_x_q;
  coef_t   a_coef;
  logic    a_adv;

  logic    b_valid_q, b_emit_q, b_last_q;
  sample_t b_w_q, b_w_d;
  logic    b_adv;

  logic    out_valid_q, hop_last_q;
  sample_t out_sample_q;

  logic signed [32:0] prod;
  logic signed [32:0] rnd;
  logic signed [16:0] sum;
  sample_t            sum_sat;
  sample_t            tail;
  sample_t            cell_q [HOP_SIZE];

  // Configuration register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      win_en_q <= 1'b1;
    end else if (cfg_we_i) begin
      win_en_q <= cfg_wdata_i;
    end
  end

  // Handshake chain: each stage moves when the next one is empty or moving.
  // Second-half samples leave stage B without needing the output register.
  assign b_adv      = b_valid_q && (!b_emit_q || !out_valid_q || out_ready_i);
  assign a_adv      = a_valid_q && (!b_valid_q || b_adv);
  assign in_ready_o = !a_valid_q || a_adv;
  assign in_xfer    = in_valid_i && in_ready_o;

  // Frame position and window address.
  assign first_half = pos_q < PW'(HOP_SIZE);
  assign rom_addr   = first_half ? pos_q[AW-1:0] : AW'(PW'(2 * HOP_SIZE - 1) - pos_q);
  assign pos_d      = (pos_q == PW'(2 * HOP_SIZE - 1)) ? '0 : pos_q + PW'(1);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q <= '0;
    end else if (in_xfer) begin
      pos_q <= pos_d;
    end
  end

  woas_rom #(
    .HOP_SIZE(HOP_SIZE)
  ) u_rom (
    .clk_i  (clk_i),
    .rd_en_i(in_xfer),
    .addr_i (rom_addr),
    .data_o (a_coef)
  );

  // Stage A: sample, coefficient (inside the table) and position flags.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      a_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      a_x_q    <= frame_sample_i;
      a_en_q   <= win_en_q;
      a_emit_q <= first_half;
      a_last_q <= (pos_q == PW'(HOP_SIZE - 1));
    end
  end

  // Windowing with round half up; the result always fits 16 bits.
  assign prod  = a_x_q * $signed({1'b0, a_coef});
  assign rnd   = prod + 33'sd32768;
  assign b_w_d = a_en_q ? rnd[31:16] : a_x_q;

  // Stage B: weighted sample.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      b_valid_q <= 1'b0;
    end else if (!b_valid_q || b_adv) begin
      b_valid_q <= a_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (a_adv) begin
      b_w_q    <= b_w_d;
      b_emit_q <= a_emit_q;
      b_last_q <= a_last_q;
    end
  end

  // Tail delay line: every weighted sample enters, and the word leaving the end
  // is the one from HOP_SIZE samples earlier, i.e. the previous frame's tail.
  for (genvar k = 0; k < HOP_SIZE; k++) begin : g_cell
    if (k == 0) begin : g_head
      woas_cell u_cell (
        .clk_i  (clk_i),
        .rst_ni (rst_ni),
        .shift_i(b_adv),
        .d_i    (b_w_q),
        .q_o    (cell_q[k])
      );
    end else begin : g_body
      woas_cell u_cell (
        .clk_i  (clk_i),
        .rst_ni (rst_ni),
        .shift_i(b_adv),
        .d_i    (cell_q[k-1]),
        .q_o    (cell_q[k])
      );
    end
  end

  assign tail    = cell_q[HOP_SIZE-1];
  assign sum     = {tail[15], tail} + {b_w_q[15], b_w_q};
  assign sum_sat = (sum[16] != sum[15]) ? (sum[16] ? 16'sh8000 : 16'sh7fff) : sum[15:0];

  // Output register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (b_adv && b_emit_q) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (b_adv && b_emit_q) begin
      out_sample_q <= sum_sat;
      hop_last_q   <= b_last_q;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign out_sample_o = out_sample_q;
  assign hop_last_o   = hop_last_q;

endmodule

`default_nettype wire

>>> design/woas_rom.sv
// Half-window Hann coefficient table with a registered read port.
`default_nettype none

module woas_rom #(
  parameter int unsigned HOP_SIZE = woas_pkg::HopSizeDefault
) (
  input  wire                            clk_i,
  input  wire                            rd_en_i,
  input  wire  [$clog2(HOP_SIZE)-1:0]    addr_i,
  output woas_pkg::coef_t                data_o
);
  import woas_pkg::*;

  localparam int unsigned FrameM1 = 2 * HOP_SIZE - 1;

  coef_t rom_w [HOP_SIZE];
  coef_t data_q;

  // The window is symmetric, so only the first half is stored.
  for (genvar i = 0; i < HOP_SIZE; i++) begin : g_coef
    localparam logic [63:0] AngleQ30 = (PI_Q30 * 64'(i)) / 64'(FrameM1);
    assign rom_w[i] = hann_coef(AngleQ30);
  end

  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      data_q <= rom_w[addr_i];
    end
  end

  assign data_o = data_q;

endmodule

`default_nettype wire

>>> design/woas_cell.sv
// One word of the overlap tail delay line.
`default_nettype none

module woas_cell (
  input  wire                    clk_i,
  input  wire                    rst_ni,
  input  wire                    shift_i,
  input  wire woas_pkg::sample_t d_i,
  output woas_pkg::sample_t      q_o
);
  import woas_pkg::*;

  sample_t word_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      word_q <= '0;
    end else if (shift_i) begin
      word_q <= d_i;
    end
  end

  assign q_o = word_q;

endmodule

`default_nettype wire

>>> design/woas_checker.sv
// Port-level checker for the overlap-add synthesizer and its bind statement.
`default_nettype none

module woas_checker #(
  parameter int unsigned HOP_SIZE = woas_pkg::HopSizeDefault
) (
  input wire                    clk_i,
  input wire                    rst_ni,
  input wire                    cfg_we_i,
  input wire                    cfg_wdata_i,
  input wire                    in_valid_i,
  input wire                    in_ready_o,
  input wire woas_pkg::sample_t frame_sample_i,
  input wire                    out_valid_o,
  input wire                    out_ready_i,
  input wire woas_pkg::sample_t out_sample_o,
  input wire                    hop_last_o
);
  import woas_pkg::*;

  localparam int unsigned PW = $clog2(2 * HOP_SIZE);
  localparam int unsigned OW = $clog2(HOP_SIZE);

  logic          in_xfer, out_xfer, emit_in;
  logic [PW-1:0] in_pos_q;
  logic [OW-1:0] out_cnt_q;
  logic [2:0]    owed_q;

  assign in_xfer  = in_valid_i && in_ready_o;
  assign out_xfer = out_valid_o && out_ready_i;
  assign emit_in  = in_xfer && (in_pos_q < PW'(HOP_SIZE));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_pos_q  <= '0;
      out_cnt_q <= '0;
      owed_q    <= '0;
    end else begin
      if (in_xfer) begin
        in_pos_q <= (in_pos_q == PW'(2 * HOP_SIZE - 1)) ? '0 : in_pos_q + PW'(1);
      end
      if (out_xfer) begin
        out_cnt_q <= (out_cnt_q == OW'(HOP_SIZE - 1)) ? '0 : out_cnt_q + OW'(1);
      end
      owed_q <= owed_q + 3'(emit_in) - 3'(out_xfer);
    end
  end

  // A waiting result holds its value.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_sample_o) && $stable(hop_last_o))
    else $error("result changed while waiting");

  // Every result belongs to an earlier first-half sample.
  a_no_extra: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_xfer |-> owed_q != 3'd0)
    else $error("result without a matching sample");

  // At most three results are in flight inside the pipeline.
  a_depth: assert property (@(posedge clk_i) disable iff (!rst_ni)
    owed_q <= 3'd3)
    else $error("too many results outstanding");

  // The hop flag marks every HOP_SIZE-th result.
  a_hop_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_xfer |-> (hop_last_o == (out_cnt_q == OW'(HOP_SIZE - 1))))
    else $error("hop flag misplaced");

  // With no result waiting the block takes a sample.
  a_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_o |-> in_ready_o)
    else $error("input stalled with an empty output");

endmodule

bind windowed_overlap_add_synth_top woas_checker #(.HOP_SIZE(HOP_SIZE)) u_woas_checker (.*);

`default_nettype wire
